### hw/rtl/pps_pkg.sv
// Shared types and constants for the preemptive priority scheduler.
`default_nettype none

package pps_pkg;

  // Result field widths are fixed by the result format
  localparam int ID_BITS     = 8;
  localparam int OUT_T_BITS  = 16;
  localparam int STATUS_BITS = 3;
  localparam int OUT_TDATA_W = ID_BITS + 3 * OUT_T_BITS;

  // Input kind codes
  localparam logic KIND_ARRIVE = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  // Result status codes
  typedef enum logic [STATUS_BITS-1:0] {
    ST_IDLE   = 3'd0,
    ST_RAN    = 3'd1,
    ST_DONE   = 3'd2,
    ST_ACCEPT = 3'd3,
    ST_REJECT = 3'd4
  } status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_ARRIVE,
    S_SCAN,
    S_DRAIN,
    S_DECIDE,
    S_FINISH
  } state_t;

  // Default parameter values
  localparam int DEF_SLOTS         = 8;
  localparam int DEF_TIME_BITS     = 16;
  localparam int DEF_PRIORITY_BITS = 4;
  localparam int DEF_BURST_BITS    = 8;

endpackage

`default_nettype wire

### hw/rtl/preemptive_priority_scheduler.sv
// Top level of the preemptive priority scheduler: task table, slot scan and result register.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+----------------------------------------------
//  in_     | in  | in_tvalid/tready   | tuser: kind; tdata: task_id, priority, burst
//  out_    | out | out_tvalid/tready  | tuser: status; tdata: run_id, finish, tat, wait
//
// An arrival is accepted, then stored and reported; a tick runs the task table scan:
// one table entry is read and compared per cycle through a single read port and one
// priority/arrival comparator.
// Reset (rst_n low, synchronous) empties the table, clears the running task and time.
// A result waiting on out_tready holds the sequencer before its table update; input
// is taken only while the sequencer is idle.
`default_nettype none

module preemptive_priority_scheduler #(
  parameter int SLOTS         = pps_pkg::DEF_SLOTS,
  parameter int TIME_BITS     = pps_pkg::DEF_TIME_BITS,
  parameter int PRIORITY_BITS = pps_pkg::DEF_PRIORITY_BITS,
  parameter int BURST_BITS    = pps_pkg::DEF_BURST_BITS,
  localparam int IN_TDATA_W   = ((pps_pkg::ID_BITS + PRIORITY_BITS + BURST_BITS + 7) / 8) * 8
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [IN_TDATA_W-1:0]            in_tdata,   // task_id, task_priority, burst_length
  input  wire logic                             in_tuser,   // kind
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [pps_pkg::OUT_TDATA_W-1:0]       out_tdata,  // run_id, finish_time, turnaround, waiting
  output logic [pps_pkg::STATUS_BITS-1:0]       out_tuser   // status
);

  import pps_pkg::*;

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CMP_W = (TIME_BITS > BURST_BITS) ? TIME_BITS : BURST_BITS;
  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  typedef struct packed {
    logic [ID_BITS-1:0]       id;
    logic [PRIORITY_BITS-1:0] pri;
    logic [TIME_BITS-1:0]     arr;
    logic [BURST_BITS-1:0]    burst;
    logic [BURST_BITS-1:0]    rem;
  } slot_t;

  // Control state
  state_t                 state_r, state_nxt;
  logic [SLOTS-1:0]       slot_valid_r;
  logic                   running_valid_r;
  logic [IDX_W-1:0]       running_slot_r;
  logic [TIME_BITS-1:0]   time_r;
  logic                   out_tvalid_r;
  logic [IDX_W-1:0]       scan_idx_r;
  logic                   cmp_vld_r;
  logic                   best_vld_r;
  logic                   run_cand_r;
  logic                   ch_vld_r;

  // Payload registers
  logic [ID_BITS-1:0]       in_id_r;
  logic [PRIORITY_BITS-1:0] in_pri_r;
  logic [BURST_BITS-1:0]    in_burst_r;
  logic [IDX_W-1:0]         cmp_idx_r;
  slot_t                    mem_q_r;
  slot_t                    best_e_r;
  logic [IDX_W-1:0]         best_idx_r;
  slot_t                    run_e_r;
  slot_t                    ch_e_r;
  logic [IDX_W-1:0]         ch_idx_r;
  logic [BURST_BITS-1:0]    ch_rem_r;
  logic [TIME_BITS-1:0]     tat_r;
  status_t                  out_status_r;
  logic [ID_BITS-1:0]       out_id_r;
  logic [OUT_T_BITS-1:0]    out_fin_r;
  logic [OUT_T_BITS-1:0]    out_tat_r;
  logic [OUT_T_BITS-1:0]    out_wt_r;

  // Task table
  slot_t mem [SLOTS];

  // Sequencer outputs
  logic scan_en;
  logic emit_arr;
  logic emit_tick;

  logic in_acc;
  logic out_free;
  logic scan_last;
  logic [IDX_W-1:0] free_idx;
  logic             free_found;
  logic             arr_ok;
  logic             ch_done;
  logic [CMP_W-1:0] tat_ext;
  logic [CMP_W-1:0] burst_ext;
  logic [TIME_BITS-1:0] wt;
  logic             use_rival;
  slot_t            pick_e;
  logic [IDX_W-1:0] pick_idx;
  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  slot_t            mem_wd;

  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;
  assign scan_last = (scan_idx_r == LAST_IDX);

  // Find the lowest free slot
  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!slot_valid_r[i]) begin
        free_idx   = IDX_W'(i);
        free_found = 1'b1;
      end
    end
  end

  assign arr_ok = free_found && (in_burst_r != '0);

  // Pick between the running task and its best rival
  always_comb begin
    use_rival = best_vld_r && (best_e_r.pri < run_e_r.pri);
    if (run_cand_r && !use_rival) begin
      pick_e   = run_e_r;
      pick_idx = running_slot_r;
    end else begin
      pick_e   = best_e_r;
      pick_idx = best_idx_r;
    end
  end

  // Completion figures
  assign ch_done   = (ch_rem_r == '0);
  assign tat_ext   = CMP_W'(tat_r);
  assign burst_ext = CMP_W'(ch_e_r.burst);
  assign wt        = (tat_ext >= burst_ext) ? TIME_BITS'(tat_ext - burst_ext) : '0;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = (in_tuser == KIND_TICK) ? S_SCAN : S_ARRIVE;
        end
      end
      S_ARRIVE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        if (scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN:  state_nxt = S_DECIDE;
      S_DECIDE: state_nxt = S_FINISH;
      S_FINISH: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_tready = 1'b0;
    scan_en   = 1'b0;
    emit_arr  = 1'b0;
    emit_tick = 1'b0;
    unique case (state_r)
      S_IDLE:   in_tready = 1'b1;
      S_ARRIVE: emit_arr  = out_free;
      S_SCAN:   scan_en   = 1'b1;
      S_DRAIN:  ;
      S_DECIDE: ;
      S_FINISH: emit_tick = out_free;
      default:  ;
    endcase
  end

  // Table write port
  always_comb begin
    mem_we = 1'b0;
    mem_wa = ch_idx_r;
    mem_wd = ch_e_r;
    mem_wd.rem = ch_rem_r;
    if (emit_arr && arr_ok) begin
      mem_we       = 1'b1;
      mem_wa       = free_idx;
      mem_wd.id    = in_id_r;
      mem_wd.pri   = in_pri_r;
      mem_wd.arr   = time_r;
      mem_wd.burst = in_burst_r;
      mem_wd.rem   = in_burst_r;
    end else if (emit_tick && ch_vld_r && !ch_done) begin
      mem_we = 1'b1;
    end
  end

  // Table storage with registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_q_r <= mem[scan_idx_r];
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Input capture, scan and compare
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r     <= '0;
      scan_idx_r <= '0;
      cmp_vld_r  <= 1'b0;
      best_vld_r <= 1'b0;
      run_cand_r <= 1'b0;
    end else begin
      cmp_vld_r <= scan_en;
      cmp_idx_r <= scan_idx_r;
      if (in_acc) begin
        in_id_r    <= in_tdata[ID_BITS-1:0];
        in_pri_r   <= in_tdata[ID_BITS +: PRIORITY_BITS];
        in_burst_r <= in_tdata[ID_BITS + PRIORITY_BITS +: BURST_BITS];
        if (in_tuser == KIND_TICK) begin
          if (time_r != TIME_MAX) begin
            time_r <= time_r + 1'b1;
          end
          scan_idx_r <= '0;
          best_vld_r <= 1'b0;
          run_cand_r <= running_valid_r && slot_valid_r[running_slot_r];
        end
      end
      // advance the scan address, hold on the last slot
      if (scan_en && !scan_last) begin
        scan_idx_r <= scan_idx_r + 1'b1;
      end
      // compare one entry against the best so far
      if (cmp_vld_r && slot_valid_r[cmp_idx_r]) begin
        if (run_cand_r && (cmp_idx_r == running_slot_r)) begin
          run_e_r <= mem_q_r;
        end else if (!best_vld_r ||
                     ({mem_q_r.pri, mem_q_r.arr} < {best_e_r.pri, best_e_r.arr})) begin
          best_vld_r <= 1'b1;
          best_e_r   <= mem_q_r;
          best_idx_r <= cmp_idx_r;
        end
      end
    end
  end

  // Decide the task for this tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_vld_r <= 1'b0;
    end else if (state_r == S_DECIDE) begin
      ch_vld_r <= run_cand_r || best_vld_r;
      ch_e_r   <= pick_e;
      ch_idx_r <= pick_idx;
      ch_rem_r <= (pick_e.rem == '0) ? '0 : pick_e.rem - 1'b1;
      tat_r    <= time_r - pick_e.arr;
    end
  end

  // Table occupancy, running task and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r    <= '0;
      running_valid_r <= 1'b0;
      running_slot_r  <= '0;
      out_tvalid_r    <= 1'b0;
    end else begin
      // drop a taken result unless a new one replaces it
      if (out_tvalid_r && out_tready && !emit_arr && !emit_tick) begin
        out_tvalid_r <= 1'b0;
      end
      // report an arrival
      if (emit_arr) begin
        out_tvalid_r <= 1'b1;
        out_id_r     <= '0;
        out_fin_r    <= '0;
        out_tat_r    <= '0;
        out_wt_r     <= '0;
        if (arr_ok) begin
          slot_valid_r[free_idx] <= 1'b1;
          out_status_r           <= ST_ACCEPT;
        end else begin
          out_status_r <= ST_REJECT;
        end
      end
      // report a tick
      if (emit_tick) begin
        out_tvalid_r <= 1'b1;
        out_fin_r    <= '0;
        out_tat_r    <= '0;
        out_wt_r     <= '0;
        if (!ch_vld_r) begin
          out_status_r    <= ST_IDLE;
          out_id_r        <= '0;
          running_valid_r <= 1'b0;
          running_slot_r  <= '0;
        end else begin
          out_id_r <= ch_e_r.id;
          if (ch_done) begin
            out_status_r           <= ST_DONE;
            out_fin_r              <= OUT_T_BITS'({{OUT_T_BITS{1'b0}}, time_r});
            out_tat_r              <= OUT_T_BITS'({{OUT_T_BITS{1'b0}}, tat_r});
            out_wt_r               <= OUT_T_BITS'({{OUT_T_BITS{1'b0}}, wt});
            slot_valid_r[ch_idx_r] <= 1'b0;
            running_valid_r        <= 1'b0;
            running_slot_r         <= '0;
          end else begin
            out_status_r    <= ST_RAN;
            running_valid_r <= 1'b1;
            running_slot_r  <= ch_idx_r;
          end
        end
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {out_wt_r, out_tat_r, out_fin_r, out_id_r};
  assign out_tuser  = out_status_r;

`ifndef SYNTH
  // The running task always occupies a live table slot
  assert property (@(posedge clk) disable iff (!rst_n)
    running_valid_r |-> slot_valid_r[running_slot_r])
    else $error("running task points at an empty slot");

  // A completed task frees its slot
  assert property (@(posedge clk) disable iff (!rst_n)
    (emit_tick && ch_vld_r && ch_done) |=> !slot_valid_r[$past(ch_idx_r)])
    else $error("completed task still holds its slot");

  // Time never runs backwards
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (time_r >= $past(time_r)))
    else $error("tick time decreased");

  // A tick result is only issued for a scanned candidate or an empty table
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DECIDE) |=> (ch_vld_r == ($past(run_cand_r) || $past(best_vld_r))))
    else $error("tick decision disagrees with scan result");
`endif

endmodule

`default_nettype wire
